@@ rtl/bvhs_pkg.sv @@
// Shared types and constants for the blood viscosity unit.
// No dependencies; other files but bvhs_chk.sv import this package.
package bvhs_pkg;

    localparam int LOG_STEPS = 24;
    localparam int DIV_STEPS = 30;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    typedef enum logic [2:0] {
        REG_A1  = 3'd0,
        REG_A2  = 3'd1,
        REG_A3  = 3'd2,
        REG_B1  = 3'd3,
        REG_B2  = 3'd4,
        REG_B3  = 3'd5,
        REG_K   = 3'd6,
        REG_NUP = 3'd7
    } t_reg;

    typedef struct packed {
        logic [15:0] hct;
        logic [4:0]  expo;
    } t_side;

    typedef struct packed {
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] a3;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] b3;
        logic [30:0] nup;
    } t_coef;

endpackage

@@ rtl/bvhs_lnorm.sv @@
// Front end: forms u = 1 + k*g in Q32.32, finds its exponent and normalizes
// the mantissa to Q1.31 over three stages. Depends on bvhs_pkg.
module bvhs_lnorm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_k,
    input  logic [31:0]     i_g,
    input  logic [15:0]     i_hct,
    output logic            o_valid,
    output logic [31:0]     o_m,
    output bvhs_pkg::t_side o_side
);
    import bvhs_pkg::*;

    logic        r_v1, r_v2, r_v3;
    logic [63:0] r_u1, r_u2;
    logic [15:0] r_h1, r_h2;
    logic [4:0]  r_e2;
    logic [31:0] r_m3;
    t_side       r_side3;
    logic [63:0] w_prod, w_sh, n_u1;
    logic [4:0]  n_e2;

    always_comb begin
        w_prod = 64'(i_k) * 64'(i_g);
        n_u1   = {w_prod[63:32] + 32'd1, w_prod[31:0]};
    end

    always_comb begin
        n_e2 = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_u1[32 + i]) begin
                n_e2 = 5'(i);
            end
        end
    end

    assign w_sh = r_u2 >> r_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1         <= n_u1;
            r_h1         <= i_hct;
            r_u2         <= r_u1;
            r_h2         <= r_h1;
            r_e2         <= n_e2;
            r_m3         <= w_sh[32:1];
            r_side3.hct  <= r_h2;
            r_side3.expo <= r_e2;
        end
    end

    assign o_valid = r_v3;
    assign o_m     = r_m3;
    assign o_side  = r_side3;

endmodule

@@ rtl/bvhs_log.sv @@
// Logarithm pipeline: one squaring stage per fraction bit of log2, then
// scaling by ln(2) and adding one. Depends on bvhs_pkg.
module bvhs_log (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_m,
    input  bvhs_pkg::t_side i_side,
    output logic            o_valid,
    output logic [28:0]     o_num,
    output logic [31:0]     o_m,
    output bvhs_pkg::t_side o_side
);
    import bvhs_pkg::*;

    logic        r_v    [LOG_STEPS];
    logic [31:0] r_m    [LOG_STEPS];
    logic [23:0] r_frac [LOG_STEPS];
    t_side       r_side [LOG_STEPS];
    logic        w_vsrc [LOG_STEPS];
    logic [31:0] w_msrc [LOG_STEPS];
    logic [23:0] w_fsrc [LOG_STEPS];
    t_side       w_ssrc [LOG_STEPS];
    logic [63:0] w_sq   [LOG_STEPS];
    logic [31:0] n_m    [LOG_STEPS];
    logic [23:0] n_frac [LOG_STEPS];
    logic        r_vl;
    logic [28:0] r_num;
    logic [31:0] r_ml;
    t_side       r_sl;
    logic [60:0] w_lnp;

    always_comb begin
        w_vsrc[0] = i_valid;
        w_msrc[0] = i_m;
        w_fsrc[0] = '0;
        w_ssrc[0] = i_side;
        for (int s = 1; s < LOG_STEPS; s++) begin
            w_vsrc[s] = r_v[s - 1];
            w_msrc[s] = r_m[s - 1];
            w_fsrc[s] = r_frac[s - 1];
            w_ssrc[s] = r_side[s - 1];
        end
        for (int s = 0; s < LOG_STEPS; s++) begin
            w_sq[s] = 64'(w_msrc[s]) * 64'(w_msrc[s]);
            if (w_sq[s][63]) begin
                n_m[s]    = w_sq[s][63:32];
                n_frac[s] = {w_fsrc[s][22:0], 1'b1};
            end else begin
                n_m[s]    = w_sq[s][62:31];
                n_frac[s] = {w_fsrc[s][22:0], 1'b0};
            end
        end
    end

    assign w_lnp = 61'({r_side[LOG_STEPS - 1].expo, r_frac[LOG_STEPS - 1]}) * 61'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LOG_STEPS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_vl <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < LOG_STEPS; s++) begin
                r_v[s] <= w_vsrc[s];
            end
            r_vl <= r_v[LOG_STEPS - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < LOG_STEPS; s++) begin
                r_m[s]    <= n_m[s];
                r_frac[s] <= n_frac[s];
                r_side[s] <= w_ssrc[s];
            end
            r_num <= w_lnp[60:32] + 29'h100_0000;
            r_ml  <= r_m[LOG_STEPS - 1];
            r_sl  <= r_side[LOG_STEPS - 1];
        end
    end

    assign o_valid = r_vl;
    assign o_num   = r_num;
    assign o_m     = r_ml;
    assign o_side  = r_sl;

endmodule

@@ rtl/bvhs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, computing
// (num << 32) / m for the shear factor. Depends on bvhs_pkg.
module bvhs_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [28:0]     i_num,
    input  logic [31:0]     i_m,
    input  bvhs_pkg::t_side i_side,
    output logic            o_valid,
    output logic [29:0]     o_q,
    output bvhs_pkg::t_side o_side
);
    import bvhs_pkg::*;

    logic        r_v    [DIV_STEPS];
    logic [31:0] r_rem  [DIV_STEPS];
    logic [31:0] r_dvs  [DIV_STEPS];
    logic [29:0] r_q    [DIV_STEPS];
    t_side       r_side [DIV_STEPS];
    logic        w_vsrc [DIV_STEPS];
    logic [31:0] w_rsrc [DIV_STEPS];
    logic [31:0] w_dsrc [DIV_STEPS];
    logic [29:0] w_qsrc [DIV_STEPS];
    t_side       w_ssrc [DIV_STEPS];
    logic [32:0] w_rs   [DIV_STEPS];
    logic        w_ge   [DIV_STEPS];
    logic [31:0] n_rem  [DIV_STEPS];

    always_comb begin
        w_vsrc[0] = i_valid;
        w_rsrc[0] = {1'b0, i_num, 2'b00};
        w_dsrc[0] = i_m;
        w_qsrc[0] = '0;
        w_ssrc[0] = i_side;
        for (int s = 1; s < DIV_STEPS; s++) begin
            w_vsrc[s] = r_v[s - 1];
            w_rsrc[s] = r_rem[s - 1];
            w_dsrc[s] = r_dvs[s - 1];
            w_qsrc[s] = r_q[s - 1];
            w_ssrc[s] = r_side[s - 1];
        end
        for (int s = 0; s < DIV_STEPS; s++) begin
            w_rs[s] = {w_rsrc[s], 1'b0};
            w_ge[s] = w_rs[s] >= {1'b0, w_dsrc[s]};
            if (w_ge[s]) begin
                n_rem[s] = 32'(w_rs[s] - {1'b0, w_dsrc[s]});
            end else begin
                n_rem[s] = w_rs[s][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_v[s] <= w_vsrc[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_dvs[s]  <= w_dsrc[s];
                r_q[s]    <= {w_qsrc[s][28:0], w_ge[s]};
                r_side[s] <= w_ssrc[s];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS - 1];
    assign o_q     = r_q[DIV_STEPS - 1];
    assign o_side  = r_side[DIV_STEPS - 1];

endmodule

@@ rtl/bvhs_mix.sv @@
// Back end: shear factor scaling, hematocrit polynomials, blend with plasma
// viscosity and saturation to signed Q8.24 over nine stages. Depends on bvhs_pkg.
module bvhs_mix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [29:0]     i_q,
    input  bvhs_pkg::t_side i_side,
    input  bvhs_pkg::t_coef i_coef,
    output logic            o_valid,
    output logic [31:0]     o_viscosity,
    output logic            o_saturated
);
    import bvhs_pkg::*;

    logic [8:0]         r_v;
    logic [28:0]        r_f1, r_f2, r_f3, r_f4, r_f5;
    logic [15:0]        r_hc1, r_hc2, r_hc3, r_hc4, r_hc5, r_hc6, r_hc7;
    logic [23:0]        r_h2a, r_h2b, r_h3;
    logic signed [56:0] r_pa1, r_pa2, r_pa3, r_pb1, r_pb2, r_pb3;
    logic signed [34:0] r_pa, r_pb4, r_pb5, r_pb6, r_diff;
    logic signed [64:0] r_prod;
    logic signed [35:0] r_t;
    logic [47:0]        r_pn;
    logic signed [52:0] r_pt;
    logic [31:0]        r_vis;
    logic               r_sat;
    logic [36:0]        w_f;
    logic [28:0]        n_f1;
    logic [31:0]        w_hh;
    logic [39:0]        w_h3;
    logic [24:0]        w_h1x, w_h2x, w_h3x;
    logic signed [58:0] w_sa, w_sb;
    logic signed [64:0] w_psh;
    logic [16:0]        w_hc;
    logic signed [53:0] w_tot, w_nsh;
    logic [37:0]        w_nu;

    always_comb begin
        w_f = {i_q, 7'b0} >> i_side.expo;
        if (w_f[36:32] != 5'd0) begin
            n_f1 = 29'h1000_0000;
        end else begin
            n_f1 = {1'b0, w_f[31:4]};
        end
        w_hh  = 32'(i_side.hct) * 32'(i_side.hct);
        w_h3  = 40'(r_h2a) * 40'(r_hc1);
        w_h1x = {1'b0, r_hc2, 8'b0};
        w_h2x = {1'b0, r_h2b};
        w_h3x = {1'b0, r_h3};
        w_sa  = 59'(r_pa1) + 59'(r_pa2) + 59'(r_pa3);
        w_sb  = 59'(r_pb1) + 59'(r_pb2) + 59'(r_pb3);
        w_psh = r_prod >>> 28;
        w_hc  = 17'h1_0000 - {1'b0, r_hc7};
        w_tot = $signed({6'b0, r_pn}) + 54'(r_pt);
        w_nsh = w_tot >>> 16;
        w_nu  = w_nsh[37:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1  <= n_f1;
            r_hc1 <= i_side.hct;
            r_h2a <= w_hh[31:8];

            r_f2  <= r_f1;
            r_hc2 <= r_hc1;
            r_h2b <= r_h2a;
            r_h3  <= w_h3[39:16];

            r_f3  <= r_f2;
            r_hc3 <= r_hc2;
            r_pa1 <= $signed(i_coef.a1) * $signed(w_h1x);
            r_pa2 <= $signed(i_coef.a2) * $signed(w_h2x);
            r_pa3 <= $signed(i_coef.a3) * $signed(w_h3x);
            r_pb1 <= $signed(i_coef.b1) * $signed(w_h1x);
            r_pb2 <= $signed(i_coef.b2) * $signed(w_h2x);
            r_pb3 <= $signed(i_coef.b3) * $signed(w_h3x);

            r_f4  <= r_f3;
            r_hc4 <= r_hc3;
            r_pa  <= 35'(w_sa >>> 24);
            r_pb4 <= 35'(w_sb >>> 24);

            r_f5   <= r_f4;
            r_hc5  <= r_hc4;
            r_pb5  <= r_pb4;
            r_diff <= r_pa - r_pb4;

            r_hc6  <= r_hc5;
            r_pb6  <= r_pb5;
            r_prod <= r_diff * $signed({1'b0, r_f5});

            r_hc7 <= r_hc6;
            r_t   <= 36'(r_pb6) + 36'(w_psh);

            r_pn <= 48'(i_coef.nup) * 48'(w_hc);
            r_pt <= r_t * $signed({1'b0, r_hc7});

            if (w_nu[37:31] == 7'h00 || w_nu[37:31] == 7'h7F) begin
                r_vis <= w_nu[31:0];
                r_sat <= 1'b0;
            end else begin
                r_vis <= w_nu[37] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r_sat <= 1'b1;
            end
        end
    end

    assign o_valid     = r_v[8];
    assign o_viscosity = r_vis;
    assign o_saturated = r_sat;

endmodule

@@ rtl/bvhs_outq.sv @@
// Two-entry output queue that decouples the receiver's ready from the
// pipeline advance. Depends on bvhs_pkg only by convention of the unit.
module bvhs_outq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_viscosity,
    input  logic        i_saturated,
    input  logic        i_ready,
    output logic        o_en,
    output logic        o_valid,
    output logic [31:0] o_viscosity,
    output logic        o_saturated
);
    import bvhs_pkg::*;

    logic [1:0]  r_cnt;
    logic        r_wp, r_rp;
    logic [32:0] r_mem [2];
    logic        w_push, w_pop;

    assign o_en    = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_en;
    assign w_pop   = o_valid && i_ready;
    assign {o_saturated, o_viscosity} = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= {i_saturated, i_viscosity};
        end
    end

endmodule

@@ rtl/blood_viscosity_hematocrit_shear_unit.sv @@
// Top level of the blood viscosity unit: register port and pipeline.
// Depends on bvhs_pkg, bvhs_lnorm, bvhs_log, bvhs_div, bvhs_mix, bvhs_outq.
//
// Usage: each input beat carries one cell's hematocrit (Q0.16) and shear
// rate (Q20.12); each output beat carries the mixture viscosity (signed
// Q8.24) and a flag that is set when the value was clipped to that range.
// Both channels use valid and ready. Coefficients, the time constant and
// the plasma viscosity are written over the APB port at byte address 4*i
// while no beat is in flight; pready is always high and reads return the
// stored values.
// One beat enters per cycle while o_in_ready is high; the pipeline is 3
// normalization stages, 24 log2 squaring stages, one ln(2) scaling stage,
// 30 divider stages and 9 blend stages.
// A two-entry output queue lets input beats keep entering while a result
// waits; once it holds two results the whole pipeline holds and o_in_ready
// drops until the receiver takes one. Nothing is lost or repeated.
// Reset clears all valid bits, the queue and the configuration registers.
module blood_viscosity_hematocrit_shear_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_hematocrit,
    input  logic [31:0] i_shear_rate,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_viscosity,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bvhs_pkg::*;

    t_coef       r_coef;
    logic [31:0] r_k;
    t_reg        w_reg;
    logic        w_en;
    logic        w_v1, w_v2, w_v3, w_v4;
    logic [31:0] w_m1, w_m2;
    t_side       w_s1, w_s2, w_s3;
    logic [28:0] w_num;
    logic [29:0] w_q;
    logic [31:0] w_vis;
    logic        w_sat;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_k    <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                REG_A1:  r_coef.a1  <= pwdata;
                REG_A2:  r_coef.a2  <= pwdata;
                REG_A3:  r_coef.a3  <= pwdata;
                REG_B1:  r_coef.b1  <= pwdata;
                REG_B2:  r_coef.b2  <= pwdata;
                REG_B3:  r_coef.b3  <= pwdata;
                REG_K:   r_k        <= pwdata;
                REG_NUP: r_coef.nup <= pwdata[30:0];
                default: r_k        <= r_k;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_A1:  prdata = r_coef.a1;
            REG_A2:  prdata = r_coef.a2;
            REG_A3:  prdata = r_coef.a3;
            REG_B1:  prdata = r_coef.b1;
            REG_B2:  prdata = r_coef.b2;
            REG_B3:  prdata = r_coef.b3;
            REG_K:   prdata = r_k;
            REG_NUP: prdata = {1'b0, r_coef.nup};
            default: prdata = '0;
        endcase
    end

    assign o_in_ready = w_en;

    bvhs_lnorm u_lnorm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_k     (r_k),
        .i_g     (i_shear_rate),
        .i_hct   (i_hematocrit),
        .o_valid (w_v1),
        .o_m     (w_m1),
        .o_side  (w_s1)
    );

    bvhs_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_m     (w_m1),
        .i_side  (w_s1),
        .o_valid (w_v2),
        .o_num   (w_num),
        .o_m     (w_m2),
        .o_side  (w_s2)
    );

    bvhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v2),
        .i_num   (w_num),
        .i_m     (w_m2),
        .i_side  (w_s2),
        .o_valid (w_v3),
        .o_q     (w_q),
        .o_side  (w_s3)
    );

    bvhs_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_v3),
        .i_q         (w_q),
        .i_side      (w_s3),
        .i_coef      (r_coef),
        .o_valid     (w_v4),
        .o_viscosity (w_vis),
        .o_saturated (w_sat)
    );

    bvhs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v4),
        .i_viscosity (w_vis),
        .i_saturated (w_sat),
        .i_ready     (i_out_ready),
        .o_en        (w_en),
        .o_valid     (o_out_valid),
        .o_viscosity (o_viscosity),
        .o_saturated (o_saturated)
    );

endmodule

@@ rtl/bvhs_chk.sv @@
// Port-level checks for the blood viscosity unit, attached by bind.
// Depends on blood_viscosity_hematocrit_shear_unit.
module bvhs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_viscosity,
    input logic        o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_viscosity) && $stable(o_saturated))
        else $error("output payload changed while stalled");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_viscosity == 32'h7FFF_FFFF || o_viscosity == 32'h8000_0000))
        else $error("saturated beat not at a range bound");

    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input held off with no result waiting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind blood_viscosity_hematocrit_shear_unit bvhs_chk u_bvhs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_viscosity (o_viscosity),
    .o_saturated (o_saturated)
);
